### rtl/tpd_pkg.sv
// package: widths, constants, state and control types for the ternary dot product
package tpd_pkg;

    localparam int ACT_WIDTH = 16;
    localparam int LANES     = 5;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 3;
    localparam int BSCALE_W  = 16;
    localparam int TSCALE_W  = 32;
    localparam int PROD_W    = ACT_WIDTH + 1;
    localparam int LSUM_W    = PROD_W + $clog2(LANES);
    localparam int BSUM_W    = 25;
    localparam int BPROD_W   = BSUM_W + BSCALE_W;
    localparam int RSUM_W    = 46;
    localparam int OUT_W     = 48;
    localparam int LO_W      = RSUM_W / 2;
    localparam int HI_W      = RSUM_W - LO_W;
    localparam int PLO_W     = LO_W + 1 + TSCALE_W;
    localparam int PHI_W     = HI_W + TSCALE_W;
    localparam int FULL_W    = RSUM_W + TSCALE_W;
    localparam int FRAC_W    = 24;
    localparam int SHIFT_W   = FULL_W - FRAC_W;

    localparam logic signed [TSCALE_W-1:0] TSCALE_RST = TSCALE_W'(32'sd16777216);

    // powers of three that rotate each trit into the top of the byte
    localparam logic [BYTE_W-1:0] POW3 [LANES] = '{8'd1, 8'd3, 8'd9, 8'd27, 8'd81};

    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACT_WIDTH-1:0] t_act;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_BMUL,
        ST_RADD,
        ST_RMUL_LO,
        ST_RMUL_HI,
        ST_RCOMB,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic merge;
        logic bmul;
        logic radd;
        logic rclear;
    } t_acc_ctrl;

    typedef struct packed {
        logic mul_lo;
        logic mul_hi;
        logic comb;
    } t_rs_ctrl;

endpackage

### rtl/tpd_in_if.sv
// input channel: packed weight byte, activations, block scale and end marks
interface tpd_in_if;
    logic                                    valid;
    logic                                    ready;
    logic [tpd_pkg::BYTE_W-1:0]              weight_byte;
    logic [tpd_pkg::CNT_W-1:0]               trit_count;
    logic signed [tpd_pkg::ACT_WIDTH-1:0]    act_0;
    logic signed [tpd_pkg::ACT_WIDTH-1:0]    act_1;
    logic signed [tpd_pkg::ACT_WIDTH-1:0]    act_2;
    logic signed [tpd_pkg::ACT_WIDTH-1:0]    act_3;
    logic signed [tpd_pkg::ACT_WIDTH-1:0]    act_4;
    logic signed [tpd_pkg::BSCALE_W-1:0]     block_scale;
    logic                                    last_in_block;
    logic                                    last_in_row;

    modport source (
        output valid, weight_byte, trit_count, act_0, act_1, act_2, act_3, act_4,
               block_scale, last_in_block, last_in_row,
        input  ready
    );
    modport sink (
        input  valid, weight_byte, trit_count, act_0, act_1, act_2, act_3, act_4,
               block_scale, last_in_block, last_in_row,
        output ready
    );
endinterface

### rtl/tpd_out_if.sv
// output channel: one saturated row value per row
interface tpd_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [tpd_pkg::OUT_W-1:0]    row_value;

    modport source (output valid, row_value, input ready);
    modport sink   (input valid, row_value, output ready);
endinterface

### rtl/ternary_packed_dot_product.sv
// top level: ternary packed dot product with five trit lanes and a scaling sequencer
//
//  channel   dir   handshake           payload
//  i_in      in    valid / ready       weight_byte, trit_count, act_0..act_4, block_scale,
//                                      last_in_block, last_in_row
//  o_out     out   valid / ready       row_value
//  i_cfg     in    i_cfg_we            i_cfg_data -> output scale register
//
//  an ordinary item does not stall the input, so bytes stream back to back
//  an item that ends a block stalls the input for merge, block scale multiply, row sum add
//  an item that ends a row also stalls it for the two partial products of the tensor scale
//  multiply, the combine and the load of the output register
//  the output register holds a row value while the next items are taken; a new row value
//  waits in the sequencer until the previous one has gone
//  reset is synchronous; it clears both sums and sets tensor scale to 1.0
module ternary_packed_dot_product (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    tpd_in_if.sink                                 i_in,
    tpd_out_if.source                              o_out,
    input  logic                                   i_cfg_we,
    input  logic signed [tpd_pkg::TSCALE_W-1:0]    i_cfg_data
);
    tpd_pkg::t_state                        r_state;
    tpd_pkg::t_state                        n_state;
    tpd_pkg::t_acc_ctrl                     acc_ctrl;
    tpd_pkg::t_rs_ctrl                      rs_ctrl;
    tpd_pkg::t_act                          act_sel [tpd_pkg::LANES];
    tpd_pkg::t_prod                         prod [tpd_pkg::LANES];
    logic                                   in_ready;
    logic                                   in_acc;
    logic                                   load_out;
    logic                                   r_lv;
    logic                                   r_lend;
    logic                                   r_lrow;
    logic signed [tpd_pkg::BSCALE_W-1:0]    r_bscale;
    logic signed [tpd_pkg::TSCALE_W-1:0]    r_out_scale;
    logic signed [tpd_pkg::RSUM_W-1:0]      row_sum;
    logic signed [tpd_pkg::OUT_W-1:0]       row_value;
    logic                                   r_out_valid;
    logic signed [tpd_pkg::OUT_W-1:0]       r_row_value;

    assign in_acc = i_in.valid && in_ready;

    always_comb begin
        act_sel[0] = i_in.act_0;
        act_sel[1] = i_in.act_1;
        act_sel[2] = i_in.act_2;
        act_sel[3] = i_in.act_3;
        act_sel[4] = i_in.act_4;
    end

    for (genvar k = 0; k < tpd_pkg::LANES; k++) begin : g_lane
        tpd_lane u_lane (
            .i_clk         (i_clk),
            .i_load        (in_acc),
            .i_weight_byte (i_in.weight_byte),
            .i_pow3        (tpd_pkg::POW3[k]),
            .i_used        (tpd_pkg::CNT_W'(k) < i_in.trit_count),
            .i_act         (act_sel[k]),
            .o_prod        (prod[k])
        );
    end

    tpd_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (acc_ctrl),
        .i_prod    (prod),
        .i_bscale  (r_bscale),
        .o_row_sum (row_sum)
    );

    tpd_rscale u_rscale (
        .i_clk       (i_clk),
        .i_ctrl      (rs_ctrl),
        .i_row_sum   (row_sum),
        .i_scale     (r_out_scale),
        .o_row_value (row_value)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tpd_pkg::ST_RUN: begin
                if (r_lv && r_lend) n_state = tpd_pkg::ST_BMUL;
            end
            tpd_pkg::ST_BMUL:    n_state = tpd_pkg::ST_RADD;
            tpd_pkg::ST_RADD:    n_state = r_lrow ? tpd_pkg::ST_RMUL_LO : tpd_pkg::ST_RUN;
            tpd_pkg::ST_RMUL_LO: n_state = tpd_pkg::ST_RMUL_HI;
            tpd_pkg::ST_RMUL_HI: n_state = tpd_pkg::ST_RCOMB;
            tpd_pkg::ST_RCOMB:   n_state = tpd_pkg::ST_EMIT;
            tpd_pkg::ST_EMIT: begin
                if (!r_out_valid || o_out.ready) n_state = tpd_pkg::ST_RUN;
            end
            default:             n_state = tpd_pkg::ST_RUN;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        acc_ctrl = '0;
        rs_ctrl  = '0;
        in_ready = 1'b0;
        load_out = 1'b0;
        case (r_state)
            tpd_pkg::ST_RUN: begin
                acc_ctrl.merge = r_lv;
                in_ready       = !(r_lv && r_lend);
            end
            tpd_pkg::ST_BMUL:    acc_ctrl.bmul = 1'b1;
            tpd_pkg::ST_RADD:    acc_ctrl.radd = 1'b1;
            tpd_pkg::ST_RMUL_LO: rs_ctrl.mul_lo = 1'b1;
            tpd_pkg::ST_RMUL_HI: begin
                rs_ctrl.mul_hi  = 1'b1;
                acc_ctrl.rclear = 1'b1;
            end
            tpd_pkg::ST_RCOMB:   rs_ctrl.comb = 1'b1;
            tpd_pkg::ST_EMIT:    load_out = !r_out_valid || o_out.ready;
            default: begin
                acc_ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tpd_pkg::ST_RUN;
            r_lv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_scale <= tpd_pkg::TSCALE_RST;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_lv <= 1'b1;
            end else if (r_state == tpd_pkg::ST_RUN) begin
                r_lv <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_out_scale <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_lend   <= i_in.last_in_block || i_in.last_in_row;
            r_lrow   <= i_in.last_in_row;
            r_bscale <= i_in.block_scale;
        end
        if (load_out) begin
            r_row_value <= row_value;
        end
    end

    assign i_in.ready      = in_ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.row_value = r_row_value;

`ifndef SYNTHESIS
    a_end_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in.last_in_block || i_in.last_in_row) |=> !i_in.ready)
        else $error("input taken right after a block end item");

    a_load_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == tpd_pkg::ST_EMIT)
        else $error("row value appeared outside the emit step");

    a_lanes_idle_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != tpd_pkg::ST_RUN |-> !r_lv)
        else $error("lane products pending during scaling sequence");

    a_row_end_scales: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tpd_pkg::ST_RADD && r_lrow |=> r_state == tpd_pkg::ST_RMUL_LO)
        else $error("row end item did not start the tensor scale multiply");
`endif
endmodule

### rtl/tpd_lane.sv
// one lane: decodes a trit and registers weight times activation
module tpd_lane (
    input  logic                            i_clk,
    input  logic                            i_load,
    input  logic [tpd_pkg::BYTE_W-1:0]      i_weight_byte,
    input  logic [tpd_pkg::BYTE_W-1:0]      i_pow3,
    input  logic                            i_used,
    input  tpd_pkg::t_act                   i_act,
    output tpd_pkg::t_prod                  o_prod
);
    logic [2*tpd_pkg::BYTE_W-1:0] rot_full;
    logic [tpd_pkg::BYTE_W-1:0]   rot;
    logic [tpd_pkg::BYTE_W+1:0]   times3;
    logic [1:0]                   trit;
    tpd_pkg::t_prod               act_ext;
    tpd_pkg::t_prod               n_prod;
    tpd_pkg::t_prod               r_prod;

    always_comb begin
        rot_full = i_weight_byte * i_pow3;
        rot      = rot_full[tpd_pkg::BYTE_W-1:0];
        times3   = {2'b00, rot} + {1'b0, rot, 1'b0};
        // top two bits of 3*rot are the trit, 0..2
        trit     = times3[tpd_pkg::BYTE_W+1:tpd_pkg::BYTE_W];
        act_ext  = tpd_pkg::PROD_W'(i_act);
        n_prod   = '0;
        if (i_used) begin
            case (trit)
                2'd0:    n_prod = -act_ext;
                2'd2:    n_prod = act_ext;
                default: n_prod = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;
endmodule

### rtl/tpd_accum.sv
// block sum merge of the lane products, block scaling and row sum
module tpd_accum (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  tpd_pkg::t_acc_ctrl                     i_ctrl,
    input  tpd_pkg::t_prod                         i_prod [tpd_pkg::LANES],
    input  logic signed [tpd_pkg::BSCALE_W-1:0]    i_bscale,
    output logic signed [tpd_pkg::RSUM_W-1:0]      o_row_sum
);
    localparam int BS = tpd_pkg::BSUM_W;
    localparam int RS = tpd_pkg::RSUM_W;
    // room for the block sum plus a full lane total at any activation width
    localparam int BW = ((tpd_pkg::LSUM_W > BS) ? tpd_pkg::LSUM_W : BS) + 1;

    logic signed [tpd_pkg::LSUM_W-1:0]  lane_total;
    logic signed [BW-1:0]               bsum_wide;
    logic [BW-BS:0]                     bsum_top;
    logic signed [BS-1:0]               bsum_sat;
    logic signed [RS:0]                 rsum_wide;
    logic signed [RS-1:0]               rsum_sat;
    logic signed [BS-1:0]               r_block_sum;
    logic signed [RS-1:0]               r_row_sum;
    logic signed [tpd_pkg::BPROD_W-1:0] r_bprod;

    always_comb begin
        lane_total = '0;
        for (int k = 0; k < tpd_pkg::LANES; k++) begin
            lane_total = lane_total + tpd_pkg::LSUM_W'(i_prod[k]);
        end
        bsum_wide = BW'(r_block_sum) + BW'(lane_total);
        bsum_top  = bsum_wide[BW-1:BS-1];
        if (!((&bsum_top) || !(|bsum_top))) begin
            bsum_sat = bsum_wide[BW-1] ? {1'b1, {(BS-1){1'b0}}} : {1'b0, {(BS-1){1'b1}}};
        end else begin
            bsum_sat = bsum_wide[BS-1:0];
        end
        rsum_wide = (RS+1)'(r_row_sum) + (RS+1)'(r_bprod);
        if (rsum_wide[RS] != rsum_wide[RS-1]) begin
            rsum_sat = rsum_wide[RS] ? {1'b1, {(RS-1){1'b0}}} : {1'b0, {(RS-1){1'b1}}};
        end else begin
            rsum_sat = rsum_wide[RS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_sum <= '0;
            r_row_sum   <= '0;
        end else begin
            if (i_ctrl.merge) begin
                r_block_sum <= bsum_sat;
            end else if (i_ctrl.bmul) begin
                r_block_sum <= '0;
            end
            if (i_ctrl.radd) begin
                r_row_sum <= rsum_sat;
            end else if (i_ctrl.rclear) begin
                r_row_sum <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.bmul) begin
            r_bprod <= r_block_sum * i_bscale;
        end
    end

    assign o_row_sum = r_row_sum;
endmodule

### rtl/tpd_rscale.sv
// row sum times tensor scale in two partial products, floor shift and saturation
module tpd_rscale (
    input  logic                                   i_clk,
    input  tpd_pkg::t_rs_ctrl                      i_ctrl,
    input  logic signed [tpd_pkg::RSUM_W-1:0]      i_row_sum,
    input  logic signed [tpd_pkg::TSCALE_W-1:0]    i_scale,
    output logic signed [tpd_pkg::OUT_W-1:0]       o_row_value
);
    localparam int OW = tpd_pkg::OUT_W;
    localparam int SW = tpd_pkg::SHIFT_W;

    logic [tpd_pkg::LO_W-1:0]              row_lo;
    logic signed [tpd_pkg::HI_W-1:0]       row_hi;
    logic signed [tpd_pkg::FULL_W-1:0]     full;
    logic [SW-OW:0]                        top_bits;
    logic signed [tpd_pkg::PLO_W-1:0]      r_plo;
    logic signed [tpd_pkg::PHI_W-1:0]      r_phi;
    logic signed [SW-1:0]                  r_shift;

    always_comb begin
        row_lo   = i_row_sum[tpd_pkg::LO_W-1:0];
        row_hi   = i_row_sum[tpd_pkg::RSUM_W-1:tpd_pkg::LO_W];
        full     = (tpd_pkg::FULL_W'(r_phi) <<< tpd_pkg::LO_W) + tpd_pkg::FULL_W'(r_plo);
        top_bits = r_shift[SW-1:OW-1];
        if ((&top_bits) || !(|top_bits)) begin
            o_row_value = r_shift[OW-1:0];
        end else begin
            o_row_value = r_shift[SW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_lo) begin
            r_plo <= $signed({1'b0, row_lo}) * i_scale;
        end
        if (i_ctrl.mul_hi) begin
            r_phi <= row_hi * i_scale;
        end
        // dropping the low bits of a two's complement value rounds toward minus infinity
        if (i_ctrl.comb) begin
            r_shift <= full[tpd_pkg::FULL_W-1:tpd_pkg::FRAC_W];
        end
    end
endmodule

### verif/ternary_packed_dot_product_tb.sv
// testbench: random and directed rows checked against an in-bench row predictor
module ternary_packed_dot_product_tb;

    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          PHASE_ITEMS   = 105;
    localparam longint      BLK_MAX       = 64'sd16777215;
    localparam longint      BLK_MIN       = -64'sd16777216;
    localparam longint      ROW_MAX       = 64'sd35184372088831;
    localparam longint      ROW_MIN       = -64'sd35184372088832;
    localparam longint      OUT_MAX       = 64'sd140737488355327;
    localparam longint      OUT_MIN       = -64'sd140737488355328;

    typedef struct packed {
        logic [tpd_pkg::BYTE_W-1:0]          weight_byte;
        logic [tpd_pkg::CNT_W-1:0]           trit_count;
        tpd_pkg::t_act [tpd_pkg::LANES-1:0]  act;
        logic signed [tpd_pkg::BSCALE_W-1:0] block_scale;
        logic                                last_in_block;
        logic                                last_in_row;
    } t_tq_byte;

    logic                                i_clk;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we;
    logic signed [tpd_pkg::TSCALE_W-1:0] i_cfg_data;

    tpd_in_if  u_in_if ();
    tpd_out_if u_out_if ();

    ternary_packed_dot_product u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (u_in_if.sink),
        .o_out      (u_out_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state
    logic signed [tpd_pkg::TSCALE_W-1:0] out_scale_q = tpd_pkg::TSCALE_RST;
    longint                              blk_sum_q   = 0;
    longint                              row_sum_q   = 0;

    t_tq_byte                            pending_bytes [$];
    logic signed [tpd_pkg::OUT_W-1:0]    expected_rows [$];
    t_tq_byte                            offered;
    logic signed [tpd_pkg::OUT_W-1:0]    want_row;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          hold_left      = 0;
    bit          hold_request   = 1'b0;
    int          cycle_count    = 0;
    int          fail_count     = 0;
    int          phase_items;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic longint clamp_sum(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void accumulate_byte(input t_tq_byte it);
        longint                 lane_sum;
        int                     pow3;
        int                     rot;
        int                     trit;
        logic signed [95:0]     scaled;
        lane_sum = 0;
        pow3     = 1;
        for (int n = 0; n < tpd_pkg::LANES; n++) begin
            if (n < int'(it.trit_count)) begin
                // multiplying by 3^n brings trit n to the top third of the byte
                rot      = (int'(it.weight_byte) * pow3) % 256;
                trit     = (rot * 3) >> 8;
                lane_sum += longint'(trit - 1) * longint'($signed(it.act[n]));
            end
            pow3 = pow3 * 3;
        end
        blk_sum_q = clamp_sum(blk_sum_q + lane_sum, BLK_MIN, BLK_MAX);
        if (it.last_in_block || it.last_in_row) begin
            row_sum_q = clamp_sum(row_sum_q + blk_sum_q * longint'($signed(it.block_scale)),
                                  ROW_MIN, ROW_MAX);
            blk_sum_q = 0;
        end
        if (it.last_in_row) begin
            scaled = row_sum_q;
            scaled = (scaled * out_scale_q) >>> tpd_pkg::FRAC_W;
            if (scaled > OUT_MAX) scaled = OUT_MAX;
            if (scaled < OUT_MIN) scaled = OUT_MIN;
            expected_rows.push_back(scaled[tpd_pkg::OUT_W-1:0]);
            row_sum_q = 0;
        end
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            u_in_if.valid <= 1'b0;
        end else begin
            if (u_in_if.valid && u_in_if.ready) begin
                accumulate_byte(offered);
            end
            if (!u_in_if.valid || u_in_if.ready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    offered = pending_bytes.pop_front();
                    u_in_if.weight_byte   <= offered.weight_byte;
                    u_in_if.trit_count    <= offered.trit_count;
                    u_in_if.act_0         <= offered.act[0];
                    u_in_if.act_1         <= offered.act[1];
                    u_in_if.act_2         <= offered.act[2];
                    u_in_if.act_3         <= offered.act[3];
                    u_in_if.act_4         <= offered.act[4];
                    u_in_if.block_scale   <= offered.block_scale;
                    u_in_if.last_in_block <= offered.last_in_block;
                    u_in_if.last_in_row   <= offered.last_in_row;
                    u_in_if.valid         <= 1'b1;
                end else begin
                    u_in_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_request) begin
            hold_left    <= HOLD_CYCLES;
            hold_request = 1'b0;
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            u_out_if.ready <= 1'b0;
        end else begin
            if (u_out_if.valid && u_out_if.ready) begin
                if (expected_rows.size() == 0) begin
                    $display("%0t: row value with none expected, actual %0d",
                             $time, u_out_if.row_value);
                    fail_count++;
                end else begin
                    want_row = expected_rows.pop_front();
                    if (u_out_if.row_value !== want_row) begin
                        $display("%0t: row value mismatch, expected %0d actual %0d",
                                 $time, want_row, u_out_if.row_value);
                        fail_count++;
                    end
                end
            end
            u_out_if.ready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic tpd_pkg::t_act pick_act();
        case ($urandom_range(7, 0))
            0: return tpd_pkg::t_act'(16'h8000);
            1: return tpd_pkg::t_act'(16'h7FFF);
            2: return tpd_pkg::t_act'(16'h0000);
            default: return tpd_pkg::t_act'($urandom);
        endcase
    endfunction

    function automatic t_tq_byte random_byte();
        t_tq_byte it;
        it.weight_byte = tpd_pkg::BYTE_W'($urandom);
        // mostly five or four trits, now and then any count
        if ($urandom_range(9, 0) == 0) begin
            it.trit_count = tpd_pkg::CNT_W'($urandom_range(7, 0));
        end else begin
            it.trit_count = $urandom_range(1, 0) ? tpd_pkg::CNT_W'(5) : tpd_pkg::CNT_W'(4);
        end
        for (int n = 0; n < tpd_pkg::LANES; n++) it.act[n] = pick_act();
        it.block_scale   = pick_act();
        it.last_in_block = 1'b0;
        it.last_in_row   = 1'b0;
        return it;
    endfunction

    task automatic push_directed(input logic [7:0] wb, input int cnt, input tpd_pkg::t_act a,
                                 input tpd_pkg::t_act bs, input bit lb, input bit lr);
        t_tq_byte it;
        it.weight_byte = wb;
        it.trit_count  = tpd_pkg::CNT_W'(cnt);
        for (int n = 0; n < tpd_pkg::LANES - 1; n++) it.act[n] = a;
        it.act[tpd_pkg::LANES-1] = ~a;
        it.block_scale   = bs;
        it.last_in_block = lb;
        it.last_in_row   = lr;
        pending_bytes.push_back(it);
    endtask

    task automatic queue_row();
        t_tq_byte it;
        int       blocks;
        int       len;
        blocks = $urandom_range(4, 1);
        for (int b = 0; b < blocks; b++) begin
            len = ($urandom_range(9, 0) == 0) ? 52 : $urandom_range(12, 1);
            for (int i = 0; i < len; i++) begin
                it = random_byte();
                if (i == len - 1) begin
                    it.last_in_block = 1'b1;
                    if (b == blocks - 1) begin
                        // row end sometimes comes without its block end mark
                        it.last_in_row   = 1'b1;
                        it.last_in_block = $urandom_range(3, 0) != 0;
                    end
                end
                pending_bytes.push_back(it);
                phase_items++;
            end
        end
    endtask

    task automatic queue_noise_row(input int len);
        t_tq_byte it;
        for (int i = 0; i < len; i++) begin
            it = random_byte();
            it.last_in_block = $urandom_range(3, 0) == 0;
            it.last_in_row   = (i == len - 1);
            pending_bytes.push_back(it);
            phase_items++;
        end
    endtask

    // all weights of one sign and full-scale activations, to drive the block sum to its limit
    task automatic queue_heavy_row(input int blocks, input int len);
        t_tq_byte it;
        bit       neg;
        neg = $urandom_range(1, 0);
        for (int b = 0; b < blocks; b++) begin
            for (int i = 0; i < len; i++) begin
                it.weight_byte = neg ? 8'h00 : 8'hFF;
                it.trit_count  = tpd_pkg::CNT_W'(5);
                for (int n = 0; n < tpd_pkg::LANES; n++) it.act[n] = tpd_pkg::t_act'(16'h7FFF);
                it.block_scale   = tpd_pkg::t_act'(16'h7FFF);
                it.last_in_block = (i == len - 1);
                it.last_in_row   = (i == len - 1) && (b == blocks - 1);
                pending_bytes.push_back(it);
                phase_items++;
            end
        end
    endtask

    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (pending_bytes.size() != 0 || u_in_if.valid || expected_rows.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_out_scale(input logic signed [tpd_pkg::TSCALE_W-1:0] scale);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= scale;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        out_scale_q = scale;
        @(negedge i_clk);
    endtask

    initial begin
        logic signed [tpd_pkg::TSCALE_W-1:0] scale;
        int                                  pick;
        u_in_if.valid         = 1'b0;
        u_in_if.weight_byte   = '0;
        u_in_if.trit_count    = '0;
        u_in_if.act_0         = '0;
        u_in_if.act_1         = '0;
        u_in_if.act_2         = '0;
        u_in_if.act_3         = '0;
        u_in_if.act_4         = '0;
        u_in_if.block_scale   = '0;
        u_in_if.last_in_block = 1'b0;
        u_in_if.last_in_row   = 1'b0;
        u_out_if.ready        = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_data            = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed rows at the reset tensor scale
        push_directed(8'h00, 5, 16'sh7FFF, 16'sh0000, 1'b0, 1'b0);
        push_directed(8'hFF, 5, 16'sh7FFF, 16'sh0000, 1'b0, 1'b0);
        push_directed(8'hFF, 5, 16'sh8000, 16'sh7FFF, 1'b1, 1'b0);
        push_directed(8'h79, 4, 16'sh8000, 16'sh0000, 1'b0, 1'b0);
        push_directed(8'h01, 0, 16'sh3039, 16'sh0000, 1'b0, 1'b0);
        push_directed(8'h80, 1, 16'shFFFF, 16'sh0000, 1'b0, 1'b0);
        push_directed(8'hAA, 2, 16'sh7FFF, 16'sh0000, 1'b0, 1'b0);
        push_directed(8'h55, 3, 16'sh8000, 16'sh0000, 1'b0, 1'b0);
        push_directed(8'hC3, 6, 16'sh03E8, 16'sh0000, 1'b0, 1'b0);
        push_directed(8'h3C, 7, 16'shFC18, 16'sh8000, 1'b0, 1'b1);
        push_directed(8'hFF, 5, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1);
        push_directed(8'h00, 5, 16'sh8000, 16'sh1000, 1'b1, 1'b1);
        push_directed(8'h00, 5, 16'sh0000, 16'sh0000, 1'b1, 1'b1);
        push_directed(8'hFF, 5, 16'sh0001, 16'sh0001, 1'b0, 1'b1);
        push_directed(8'hF2, 5, 16'sh4000, 16'shC000, 1'b1, 1'b0);
        push_directed(8'h0D, 4, 16'shC000, 16'sh7FFF, 1'b0, 1'b1);
        drain();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: scale = 32'sh7FFF_FFFF;
                1: scale = 32'sh8000_0000;
                2: scale = 32'sh0000_0000;
                3: scale = tpd_pkg::TSCALE_W'($urandom);
                4: scale = 32'shFF00_0000;
                default: begin
                    scale = tpd_pkg::TSCALE_W'(int'($urandom_range(33554432, 0)) - 16777216);
                end
            endcase
            load_out_scale(scale);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            phase_items = 0;
            // sender keeps offering while the receiver is held off
            if (p == 4) hold_request = 1'b1;
            while (phase_items < PHASE_ITEMS) begin
                pick = $urandom_range(19, 0);
                if (pick < 15) queue_row();
                else if (pick < 19) queue_noise_row($urandom_range(20, 1));
                else queue_heavy_row(1, 110);
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### files.f
rtl/tpd_pkg.sv
rtl/tpd_in_if.sv
rtl/tpd_out_if.sv
rtl/tpd_lane.sv
rtl/tpd_accum.sv
rtl/tpd_rscale.sv
rtl/ternary_packed_dot_product.sv
verif/ternary_packed_dot_product_tb.sv
